### sv/lcd_window_fill_word_generator_assert.svh
// Assertion macros for the LCD window fill word generator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LCD_WINDOW_FILL_WORD_GENERATOR_ASSERT_SVH
`define LCD_WINDOW_FILL_WORD_GENERATOR_ASSERT_SVH

// Plain clocked property, disabled while in reset
`define LWFG_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lwfg assertion failed");

// A stalled valid keeps its payload until taken
`define LWFG_ASSERT_HOLD(name, vld, rdy, data) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(data))) \
    else $error("lwfg stalled word changed");

`endif

### sv/lwfg_pkg.sv
// Shared types and constants for the LCD window fill word generator.
// No dependencies.
package lwfg_pkg;

  // Panel geometry
  localparam int unsigned PanelSize = 132;
  localparam logic [7:0]  PanelLast = 8'(PanelSize - 1);

  // Configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Triplet counter
  localparam int unsigned TripW   = 14;
  localparam logic [TripW-1:0] TripMax = '1;

  // Register indexes
  localparam logic [1:0] RegColSet = 2'd0;
  localparam logic [1:0] RegRowSet = 2'd1;
  localparam logic [1:0] RegMemWr  = 2'd2;
  localparam logic [1:0] RegNop    = 2'd3;

  // Outline sub-windows
  localparam logic [1:0] SubLeft   = 2'd0;
  localparam logic [1:0] SubRight  = 2'd1;
  localparam logic [1:0] SubTop    = 2'd2;
  localparam logic [1:0] SubBottom = 2'd3;

  // Byte position inside a colour triplet
  localparam logic [1:0] ByteFirst  = 2'd0;
  localparam logic [1:0] ByteSecond = 2'd1;
  localparam logic [1:0] ByteThird  = 2'd2;

  // Commands
  typedef enum logic [2:0] {
    CmdPixel   = 3'd0,
    CmdFill    = 3'd1,
    CmdOutline = 3'd2,
    CmdClear   = 3'd3,
    CmdPull    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    JobPixel   = 2'd0,
    JobFill    = 2'd1,
    JobOutline = 2'd2,
    JobClear   = 2'd3
  } job_e;

  // Word sequencer for one window
  typedef enum logic [7:0] {
    PhColSet   = 8'b0000_0001,
    PhColStart = 8'b0000_0010,
    PhColEnd   = 8'b0000_0100,
    PhRowSet   = 8'b0000_1000,
    PhRowStart = 8'b0001_0000,
    PhRowEnd   = 8'b0010_0000,
    PhMemWr    = 8'b0100_0000,
    PhColour   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] thickness;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
  } in_item_t;

  typedef struct packed {
    logic       valid_res;
    logic       is_data;
    logic [7:0] word_byte;
    logic       last;
  } out_item_t;

endpackage

### sv/lcd_window_fill_word_generator.sv
// LCD window fill word generator: latches draw jobs, emits one 9-bit LCD word per pull.
// Depends on lwfg_pkg.
// A pull is answered in the output register in the cycle after it is accepted.
// Throughput: one item per cycle unless a held word is stalled; a start command yields no word.
// The word register frees input ready while the output is being taken the same cycle.
// Triplet count uses the spans registered on the row-end word, so the 9x9 multiply
// sits alone in the memory-write cycle.
// Reset (rst_ni, async low): idle, opcode registers at 42, 43, 44 and 0, no word held.
module lcd_window_fill_word_generator
  import lwfg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Opcode registers
  logic [7:0] op_col_q, op_row_q, op_mem_q, op_nop_q;
  logic       cfg_wr;
  logic [7:0] cfg_rd;

  // Job state
  logic             busy_q, busy_d;
  job_e             job_q, job_d;
  logic [1:0]       sub_q, sub_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       x_q, y_q, w_q, h_q, t_q;
  logic [3:0]       red_q, green_q, blue_q;
  logic [TripW-1:0] trip_q, trip_d;
  logic [1:0]       pos_q, pos_d;
  logic [7:0]       span_x_q, span_y_q;

  // Output word register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic in_acc, start, pull;

  // Window corners
  logic [7:0] c0, c1, r0, r1;

  // Triplet count
  logic [8:0]       len_x, len_y;
  logic [17:0]      area;
  logic [16:0]      cnt_raw;
  logic [TripW-1:0] cnt;
  logic [TripW-1:0] trip_m1;

  // ---------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_col_q <= 8'd42;
      op_row_q <= 8'd43;
      op_mem_q <= 8'd44;
      op_nop_q <= 8'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegColSet: op_col_q <= pwdata[7:0];
        RegRowSet: op_row_q <= pwdata[7:0];
        RegMemWr:  op_mem_q <= pwdata[7:0];
        RegNop:    op_nop_q <= pwdata[7:0];
        default:   op_nop_q <= op_nop_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegColSet: cfg_rd = op_col_q;
      RegRowSet: cfg_rd = op_row_q;
      RegMemWr:  cfg_rd = op_mem_q;
      RegNop:    cfg_rd = op_nop_q;
      default:   cfg_rd = 8'd0;
    endcase
  end
  assign prdata = {{(DataW - 8){1'b0}}, cfg_rd};

  // ---------------------------------------------------------------------
  // Handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && (in_data_i.command == CmdPixel ||
                                 in_data_i.command == CmdFill ||
                                 in_data_i.command == CmdOutline ||
                                 in_data_i.command == CmdClear);
  assign pull       = in_acc && (in_data_i.command == CmdPull);

  // ---------------------------------------------------------------------
  // Current window, 8-bit wrapping arithmetic
  always_comb begin
    c0 = x_q;
    c1 = x_q + w_q;
    r0 = y_q;
    r1 = y_q + h_q;
    unique case (job_q)
      JobPixel: begin
        c1 = x_q;
        r1 = y_q;
      end
      JobClear: begin
        c0 = 8'd0;
        r0 = 8'd0;
        c1 = PanelLast;
        r1 = PanelLast;
      end
      JobOutline: begin
        unique case (sub_q)
          SubLeft:   c1 = x_q + t_q - 8'd1;
          SubRight:  c0 = x_q + w_q - t_q + 8'd1;
          SubTop:    r1 = y_q + t_q - 8'd1;
          SubBottom: r0 = y_q + h_q - t_q + 8'd1;
          default:   c0 = x_q;
        endcase
      end
      default: c0 = x_q;
    endcase
  end

  // Triplets for the window: (dx+1)(dy+1)/2+1, saturated
  assign len_x   = {1'b0, span_x_q} + 9'd1;
  assign len_y   = {1'b0, span_y_q} + 9'd1;
  assign area    = len_x * len_y;
  assign cnt_raw = area[17:1] + 17'd1;
  assign cnt     = (cnt_raw > 17'(TripMax)) ? TripMax : cnt_raw[TripW-1:0];
  assign trip_m1 = trip_q - 1'b1;

  // ---------------------------------------------------------------------
  // Next-state and word generation
  always_comb begin
    busy_d      = busy_q;
    job_d       = job_q;
    sub_d       = sub_q;
    phase_d     = phase_q;
    trip_d      = trip_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (start) begin
      busy_d  = 1'b1;
      job_d   = job_e'(in_data_i.command[1:0]);
      sub_d   = SubLeft;
      phase_d = PhColSet;
      trip_d  = '0;
      pos_d   = ByteFirst;
    end else if (pull) begin
      out_valid_d         = 1'b1;
      out_d.valid_res     = busy_q;
      out_d.is_data       = busy_q;
      out_d.word_byte     = 8'd0;
      out_d.last          = 1'b0;
      if (busy_q) begin
        unique case (phase_q)
          PhColSet: begin
            out_d.is_data   = 1'b0;
            out_d.word_byte = op_col_q;
            phase_d         = PhColStart;
          end
          PhColStart: begin
            out_d.word_byte = c0;
            phase_d         = PhColEnd;
          end
          PhColEnd: begin
            out_d.word_byte = c1;
            phase_d         = PhRowSet;
          end
          PhRowSet: begin
            out_d.is_data   = 1'b0;
            out_d.word_byte = op_row_q;
            phase_d         = PhRowStart;
          end
          PhRowStart: begin
            out_d.word_byte = r0;
            phase_d         = PhRowEnd;
          end
          PhRowEnd: begin
            out_d.word_byte = r1;
            phase_d         = PhMemWr;
          end
          PhMemWr: begin
            out_d.is_data   = 1'b0;
            out_d.word_byte = op_mem_q;
            phase_d         = PhColour;
            pos_d           = ByteFirst;
            trip_d          = cnt;
          end
          PhColour: begin
            if (job_q == JobPixel) begin
              // single pixel: two colour bytes then a no-op
              priority case (pos_q)
                ByteFirst: begin
                  out_d.word_byte = {red_q, green_q};
                  pos_d           = ByteSecond;
                end
                ByteSecond: begin
                  out_d.word_byte = {blue_q, 4'h0};
                  pos_d           = ByteThird;
                end
                default: begin
                  out_d.is_data   = 1'b0;
                  out_d.word_byte = op_nop_q;
                  out_d.last      = 1'b1;
                  busy_d          = 1'b0;
                  phase_d         = PhColSet;
                  pos_d           = ByteFirst;
                end
              endcase
            end else begin
              // packed triplets: RG, BR, GB
              priority case (pos_q)
                ByteFirst: begin
                  out_d.word_byte = {red_q, green_q};
                  pos_d           = ByteSecond;
                end
                ByteSecond: begin
                  out_d.word_byte = {blue_q, red_q};
                  pos_d           = ByteThird;
                end
                default: begin
                  out_d.word_byte = {green_q, blue_q};
                  pos_d           = ByteFirst;
                  trip_d          = trip_m1;
                  if (trip_m1 == '0) begin
                    phase_d = PhColSet;
                    if (job_q == JobOutline && sub_q != SubBottom) begin
                      sub_d = sub_q + 2'd1;
                    end else begin
                      out_d.last = 1'b1;
                      busy_d     = 1'b0;
                      sub_d      = SubLeft;
                    end
                  end
                end
              endcase
            end
          end
          default: phase_d = PhColSet;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      job_q       <= JobPixel;
      sub_q       <= SubLeft;
      phase_q     <= PhColSet;
      trip_q      <= '0;
      pos_q       <= ByteFirst;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      job_q       <= job_d;
      sub_q       <= sub_d;
      phase_q     <= phase_d;
      trip_q      <= trip_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: shape, colour, spans, word
  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q     <= in_data_i.x_start;
      y_q     <= in_data_i.y_start;
      w_q     <= in_data_i.width;
      h_q     <= in_data_i.height;
      t_q     <= in_data_i.thickness;
      red_q   <= in_data_i.red;
      green_q <= in_data_i.green;
      blue_q  <= in_data_i.blue;
    end
    if (pull && phase_q == PhRowEnd) begin
      span_x_q <= c1 - c0;
      span_y_q <= r1 - r0;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/lwfg_checker.sv
// Port-level checker for the LCD window fill word generator, bound to the top level.
// Depends on lwfg_pkg and lcd_window_fill_word_generator_assert.svh.
`include "lcd_window_fill_word_generator_assert.svh"

module lwfg_checker
  import lwfg_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input in_item_t         in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input out_item_t        out_data_o
);

  logic in_take;
  logic idle_word_zero;

  // Input word taken this cycle
  assign in_take = in_valid_i && in_ready_o;

  // Idle answer carries no flags and a zero byte
  assign idle_word_zero = (out_data_o.word_byte == 8'h00) && !out_data_o.is_data &&
                          !out_data_o.last;

  // A stalled word holds
  `LWFG_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_data_o)

  // Input is never blocked while the word register is empty
  `LWFG_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)

  // Every accepted pull yields a word on the next cycle
  `LWFG_ASSERT(a_pull_word, (in_take && in_data_i.command == CmdPull) |=> out_valid_o)

  // A start command produces no word
  `LWFG_ASSERT(a_start_silent, (in_take && in_data_i.command != CmdPull) |=> !out_valid_o)

  // Idle answer is all zero
  `LWFG_ASSERT(a_idle_zero, (out_valid_o && !out_data_o.valid_res) |-> idle_word_zero)

endmodule

bind lcd_window_fill_word_generator lwfg_checker u_lwfg_checker (.*);
